// File: rtl/rlbm_pkg.sv
// Shared types and constants for the RGB LED button mode controller.
// No dependencies; imported by every module of the block.
package rlbm_pkg;

  // Operating mode codes
  typedef enum logic [1:0] {
    MODE_AUTO  = 2'd0,
    MODE_RED   = 2'd1,
    MODE_BLUE  = 2'd2,
    MODE_GREEN = 2'd3
  } mode_t;

  // Button debouncer states (shared by the fast and gesture debouncers)
  typedef enum logic [1:0] {
    DB_IDLE = 2'd0,
    DB_SEEN = 2'd1,
    DB_HELD = 2'd2
  } deb_t;

  // Cross-fade phases; the fourth code leaves the levels alone
  typedef enum logic [1:0] {
    PH_RED_GREEN  = 2'd0,
    PH_GREEN_BLUE = 2'd1,
    PH_BLUE_RED   = 2'd2
  } phase_t;

  // Configuration register indexes
  localparam logic CFG_PERIOD_LOAD = 1'b0;
  localparam logic CFG_LONG_PRESS  = 1'b1;

  localparam logic [15:0] PERIOD_LOAD_RST = 16'd11362;
  localparam logic [7:0]  LONG_PRESS_RST  = 8'd200;

  localparam logic [7:0] LEVEL_MAX  = 8'd251;
  localparam logic [7:0] LEVEL_MIN  = 8'd1;
  localparam logic [7:0] LEVEL_STEP = 8'd5;
  localparam logic [4:0] SPEED_MAX  = 5'd20;
  localparam logic [4:0] SPEED_MIN  = 5'd1;
  localparam logic [4:0] SPEED_RST  = 5'd10;
  localparam logic [2:0] COUNT_MAX  = 3'd7;

  // Duty = level * load / 1000, done as a reciprocal multiply.
  // With a 24-bit product, ceil(2^34 / 1000) is exact for every operand.
  localparam int          PROD_W     = 24;
  localparam int          RECIP_W    = 25;
  localparam int          DUTY_SHIFT = 34;
  localparam int          DUTY_W     = 15;
  localparam int          QUO_W      = PROD_W + RECIP_W;
  localparam logic [RECIP_W-1:0] DUTY_RECIP = 25'd17179870;
  localparam int          NUM_LANES  = 3;
  localparam int          LANE_RED   = 0;
  localparam int          LANE_GREEN = 1;
  localparam int          LANE_BLUE  = 2;

  // Levels and mode handed from the state update to the duty pipeline
  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    mode_t      mode;
  } levels_t;

endpackage

// File: rtl/rgb_led_button_mode_controller_unit.sv
// Top level of the RGB LED button mode controller: configuration registers,
// state update and duty pipeline. Depends on rlbm_pkg, rlbm_ctrl, rlbm_duty.
//
// Usage:
//   Each input item is one tick with the two sampled button bits
//   (in_valid / in_ready). Each item yields exactly one result item
//   (out_valid / out_ready) with the three levels, their pulse widths
//   level * period_load / 1000 and the current mode.
//   Throughput is one item per clock cycle while out_ready stays high. A
//   result reaches out_valid through these registers in order: the accepting
//   edge updates the controller state, the duty stage registers level * load,
//   and the output register takes the finished reciprocal divide.
//   Configuration writes (cfg_we, cfg_index, cfg_wdata) take effect at the
//   next edge and are meant for an idle block.
//   Reset (rst_n low at a clock edge) restores the register defaults, the
//   automatic fade state and empties the pipeline.
//   When out_ready is low the stages fill up and in_ready drops once every
//   stage holds an item; nothing is lost or repeated.
module rgb_led_button_mode_controller_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_button_one_pressed,
  input  logic        in_button_two_pressed,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_red_level,
  output logic [7:0]  out_green_level,
  output logic [7:0]  out_blue_level,
  output logic [14:0] out_red_duty,
  output logic [14:0] out_green_duty,
  output logic [14:0] out_blue_duty,
  output logic [1:0]  out_current_mode,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [15:0] cfg_wdata
);
  import rlbm_pkg::*;

  logic [15:0]       period_load_r;
  logic [7:0]        long_press_r;
  logic              lvl_valid, lvl_ready;
  levels_t           lvl, lvl_out;
  logic [DUTY_W-1:0] duty [NUM_LANES];

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      period_load_r <= PERIOD_LOAD_RST;
      long_press_r  <= LONG_PRESS_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_PERIOD_LOAD: period_load_r <= cfg_wdata;
        CFG_LONG_PRESS:  long_press_r  <= cfg_wdata[7:0];
        default:         period_load_r <= period_load_r;
      endcase
    end
  end

  rlbm_ctrl u_ctrl (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .button_one       (in_button_one_pressed),
    .button_two       (in_button_two_pressed),
    .long_press_ticks (long_press_r),
    .lvl_valid        (lvl_valid),
    .lvl_ready        (lvl_ready),
    .lvl              (lvl)
  );

  rlbm_duty u_duty (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (lvl_valid),
    .in_ready    (lvl_ready),
    .lvl_in      (lvl),
    .period_load (period_load_r),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .lvl_out     (lvl_out),
    .duty        (duty)
  );

  // Split the result item onto its ports
  assign out_red_level    = lvl_out.red;
  assign out_green_level  = lvl_out.green;
  assign out_blue_level   = lvl_out.blue;
  assign out_current_mode = lvl_out.mode;
  assign out_red_duty     = duty[LANE_RED];
  assign out_green_duty   = duty[LANE_GREEN];
  assign out_blue_duty    = duty[LANE_BLUE];

endmodule

// File: rtl/rlbm_ctrl.sv
// Per-tick state update: debouncers, long-press timers, mode gestures,
// fade and manual level steps. Depends on rlbm_pkg.
module rlbm_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              button_one,
  input  logic              button_two,
  input  logic [7:0]        long_press_ticks,
  output logic              lvl_valid,
  input  logic              lvl_ready,
  output rlbm_pkg::levels_t lvl
);
  import rlbm_pkg::*;

  deb_t       fd1_r, fd2_r, gd1_r, gd2_r;
  deb_t       fd1_nxt, fd2_nxt, gd1_nxt, gd2_nxt;
  logic [7:0] ht1_r, ht2_r, ht1_nxt, ht2_nxt;
  logic [2:0] spc_r, spc_nxt;
  mode_t      mode_r, mode_nxt;
  logic [4:0] speed_r, speed_nxt, div_r, div_nxt;
  phase_t     phase_r, phase_nxt;
  logic [7:0] red_r, green_r, blue_r, red_nxt, green_nxt, blue_nxt;
  logic       v1_r;
  logic       take;

  function automatic logic [7:0] hold_step(input logic [7:0] t, input logic [7:0] thr);
    hold_step = (t >= thr) ? t : t + 8'd1;
  endfunction

  function automatic logic [7:0] level_up(input logic [7:0] v);
    level_up = (v >= LEVEL_MAX - LEVEL_STEP + 8'd1) ? LEVEL_MAX : v + LEVEL_STEP;
  endfunction

  function automatic logic [7:0] level_down(input logic [7:0] v);
    level_down = (v <= LEVEL_MIN + LEVEL_STEP) ? LEVEL_MIN : v - LEVEL_STEP;
  endfunction

  function automatic deb_t deb_step(input deb_t st, input logic pressed);
    deb_t nx;
    nx = st;
    if (!pressed) begin
      nx = DB_IDLE;
    end else begin
      case (st)
        DB_IDLE: nx = DB_SEEN;
        DB_SEEN: nx = DB_HELD;
        default: nx = st;
      endcase
    end
    deb_step = nx;
  endfunction

  // Advance when the downstream stage frees up
  assign in_ready  = !v1_r || lvl_ready;
  assign take      = in_valid && in_ready;
  assign lvl_valid = v1_r;
  assign lvl.red   = red_r;
  assign lvl.green = green_r;
  assign lvl.blue  = blue_r;
  assign lvl.mode  = mode_r;

  // Next state for one tick
  always_comb begin
    logic long1, long2, frozen, up, down;
    fd1_nxt   = fd1_r;
    fd2_nxt   = fd2_r;
    gd1_nxt   = gd1_r;
    gd2_nxt   = gd2_r;
    ht1_nxt   = ht1_r;
    ht2_nxt   = ht2_r;
    spc_nxt   = spc_r;
    mode_nxt  = mode_r;
    speed_nxt = speed_r;
    div_nxt   = div_r;
    phase_nxt = phase_r;
    red_nxt   = red_r;
    green_nxt = green_r;
    blue_nxt  = blue_r;
    long1     = 1'b0;
    long2     = 1'b0;
    up        = 1'b0;
    down      = 1'b0;

    // Button two: debounce, then time the hold; decide mode on release
    if (button_two) begin
      if (gd2_r != DB_HELD) begin
        gd2_nxt = deb_step(gd2_r, 1'b1);
      end else begin
        ht2_nxt = hold_step(ht2_r, long_press_ticks);
      end
    end else begin
      gd2_nxt = DB_IDLE;
      if (ht2_r >= long_press_ticks) begin
        if (ht1_r >= long_press_ticks) begin
          mode_nxt = MODE_GREEN;
        end else if (spc_r == 3'd2) begin
          mode_nxt = MODE_BLUE;
        end else if (spc_r == 3'd1) begin
          mode_nxt = MODE_RED;
        end
      end
      ht2_nxt = 8'd0;
    end

    // Button one counts presses only while button two is held
    if (gd2_nxt == DB_HELD) begin
      if (button_one) begin
        if (gd1_r != DB_HELD) begin
          gd1_nxt = deb_step(gd1_r, 1'b1);
        end else begin
          ht1_nxt = hold_step(ht1_r, long_press_ticks);
        end
      end else begin
        if (gd1_r == DB_HELD) begin
          long1 = ht1_r >= long_press_ticks;
          long2 = ht2_nxt >= long_press_ticks;
          if (long1 && long2) begin
            mode_nxt = MODE_GREEN;
            spc_nxt  = 3'd0;
          end else if (spc_r < COUNT_MAX) begin
            spc_nxt = spc_r + 3'd1;
          end
          ht1_nxt = 8'd0;
        end
        gd1_nxt = DB_IDLE;
      end
    end else begin
      gd1_nxt = DB_IDLE;
      ht1_nxt = 8'd0;
      spc_nxt = 3'd0;
    end

    frozen = (gd2_nxt == DB_HELD && gd1_nxt == DB_HELD) ||
             (ht2_nxt >= long_press_ticks);

    if (!frozen) begin
      up      = button_one && (fd1_r == DB_SEEN);
      down    = button_two && (fd2_r == DB_SEEN);
      fd1_nxt = deb_step(fd1_r, button_one);
      fd2_nxt = deb_step(fd2_r, button_two);
      if (mode_nxt == MODE_AUTO) begin
        // Cross-fade one step when the divider runs out
        if (div_r == 5'd0) begin
          case (phase_r)
            PH_RED_GREEN: begin
              red_nxt   = red_r - LEVEL_STEP;
              green_nxt = green_r + LEVEL_STEP;
              if (red_nxt == LEVEL_MIN) phase_nxt = PH_GREEN_BLUE;
            end
            PH_GREEN_BLUE: begin
              green_nxt = green_r - LEVEL_STEP;
              blue_nxt  = blue_r + LEVEL_STEP;
              if (green_nxt == LEVEL_MIN) phase_nxt = PH_BLUE_RED;
            end
            PH_BLUE_RED: begin
              blue_nxt = blue_r - LEVEL_STEP;
              red_nxt  = red_r + LEVEL_STEP;
              if (blue_nxt == LEVEL_MIN) phase_nxt = PH_RED_GREEN;
            end
            default: phase_nxt = phase_r;
          endcase
          div_nxt = speed_r;
        end else begin
          div_nxt = div_r - 5'd1;
        end
        // Button one speeds the fade up, button two slows it down
        if (up) begin
          speed_nxt = (speed_r <= SPEED_MIN) ? SPEED_MIN : speed_r - 5'd1;
        end
        if (down) begin
          speed_nxt = (speed_nxt >= SPEED_MAX) ? SPEED_MAX : speed_nxt + 5'd1;
        end
      end else begin
        // Manual mode: step the selected level
        case (mode_nxt)
          MODE_RED: begin
            if (up)   red_nxt = level_up(red_nxt);
            if (down) red_nxt = level_down(red_nxt);
          end
          MODE_BLUE: begin
            if (up)   blue_nxt = level_up(blue_nxt);
            if (down) blue_nxt = level_down(blue_nxt);
          end
          default: begin
            if (up)   green_nxt = level_up(green_nxt);
            if (down) green_nxt = level_down(green_nxt);
          end
        endcase
      end
    end
  end

  // Hold state; update it on each accepted item
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r    <= 1'b0;
      fd1_r   <= DB_IDLE;
      fd2_r   <= DB_IDLE;
      gd1_r   <= DB_IDLE;
      gd2_r   <= DB_IDLE;
      ht1_r   <= 8'd0;
      ht2_r   <= 8'd0;
      spc_r   <= 3'd0;
      mode_r  <= MODE_AUTO;
      speed_r <= SPEED_RST;
      div_r   <= SPEED_RST;
      phase_r <= PH_RED_GREEN;
      red_r   <= LEVEL_MAX;
      green_r <= LEVEL_MIN;
      blue_r  <= LEVEL_MIN;
    end else begin
      if (in_ready) begin
        v1_r <= in_valid;
      end
      if (take) begin
        fd1_r   <= fd1_nxt;
        fd2_r   <= fd2_nxt;
        gd1_r   <= gd1_nxt;
        gd2_r   <= gd2_nxt;
        ht1_r   <= ht1_nxt;
        ht2_r   <= ht2_nxt;
        spc_r   <= spc_nxt;
        mode_r  <= mode_nxt;
        speed_r <= speed_nxt;
        div_r   <= div_nxt;
        phase_r <= phase_nxt;
        red_r   <= red_nxt;
        green_r <= green_nxt;
        blue_r  <= blue_nxt;
      end
    end
  end

endmodule

// File: rtl/rlbm_duty.sv
// Two-stage duty pipeline: level * load, then divide by 1000 through a
// reciprocal multiply into the output register. Depends on rlbm_pkg.
module rlbm_duty (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  rlbm_pkg::levels_t       lvl_in,
  input  logic [15:0]             period_load,
  output logic                    out_valid,
  input  logic                    out_ready,
  output rlbm_pkg::levels_t       lvl_out,
  output logic [rlbm_pkg::DUTY_W-1:0] duty [rlbm_pkg::NUM_LANES]
);
  import rlbm_pkg::*;

  logic              v2_r, v3_r, rdy2, rdy3;
  levels_t           pay2_r, pay3_r;
  logic [7:0]        lane_lvl [NUM_LANES];
  logic [PROD_W-1:0] prod [NUM_LANES];
  logic [PROD_W-1:0] prod2_r [NUM_LANES];
  logic [QUO_W-1:0]  quo [NUM_LANES];
  logic [DUTY_W-1:0] duty3_r [NUM_LANES];

  // Stage readiness
  assign rdy3      = !v3_r || out_ready;
  assign rdy2      = !v2_r || rdy3;
  assign in_ready  = rdy2;
  assign out_valid = v3_r;
  assign lvl_out   = pay3_r;
  assign duty      = duty3_r;

  assign lane_lvl[LANE_RED]   = lvl_in.red;
  assign lane_lvl[LANE_GREEN] = lvl_in.green;
  assign lane_lvl[LANE_BLUE]  = lvl_in.blue;

  // Scale and divide per lane
  always_comb begin
    for (int i = 0; i < NUM_LANES; i++) begin
      prod[i] = PROD_W'(lane_lvl[i]) * PROD_W'(period_load);
      quo[i]  = QUO_W'(prod2_r[i]) * QUO_W'(DUTY_RECIP);
    end
  end

  // Advance valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      if (rdy2) v2_r <= in_valid;
      if (rdy3) v3_r <= v2_r;
    end
  end

  // Move payload through the stages
  always_ff @(posedge clk) begin
    if (rdy2 && in_valid) begin
      pay2_r  <= lvl_in;
      prod2_r <= prod;
    end
    if (rdy3 && v2_r) begin
      pay3_r <= pay2_r;
      for (int i = 0; i < NUM_LANES; i++) begin
        duty3_r[i] <= quo[i][DUTY_SHIFT +: DUTY_W];
      end
    end
  end

endmodule

// File: rtl/rlbm_checker.sv
// Port-level checks for the RGB LED button mode controller, bound to the
// top level. Depends on rlbm_pkg and rgb_led_button_mode_controller_unit.
module rlbm_port_checks (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic [7:0]  out_red_level,
  input logic [7:0]  out_green_level,
  input logic [7:0]  out_blue_level,
  input logic [14:0] out_red_duty,
  input logic [1:0]  out_current_mode
);
  import rlbm_pkg::*;

  // Stalled result holds its red level, red duty and mode
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_red_level) &&
      $stable(out_red_duty) && $stable(out_current_mode))
    else $error("stalled result changed");

  // Levels stay within 1..251
  a_level_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_red_level >= LEVEL_MIN && out_red_level <= LEVEL_MAX &&
      out_green_level >= LEVEL_MIN && out_green_level <= LEVEL_MAX &&
      out_blue_level >= LEVEL_MIN && out_blue_level <= LEVEL_MAX)
    else $error("level out of range");

  // Reset empties the pipeline
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result shown right after reset");

  // A manual mode never falls back to automatic fade
  a_no_auto_return: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && out_current_mode != MODE_AUTO |=>
      !(out_valid && out_current_mode == MODE_AUTO))
    else $error("mode returned to automatic");

endmodule

bind rgb_led_button_mode_controller_unit rlbm_port_checks u_rlbm_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .out_valid        (out_valid),
  .out_ready        (out_ready),
  .out_red_level    (out_red_level),
  .out_green_level  (out_green_level),
  .out_blue_level   (out_blue_level),
  .out_red_duty     (out_red_duty),
  .out_current_mode (out_current_mode)
);
